### rtl/core/hlr_pkg.sv
`default_nettype none

package hlr_pkg;

    // sizing of the stack and the bar heights
    localparam int unsigned MAX_BARS    = 1024;
    localparam int unsigned HEIGHT_BITS = 16;

    // counters must hold MAX_BARS itself, stack pointers only index it
    localparam int unsigned CNT_W  = $clog2(MAX_BARS + 1);
    localparam int unsigned PTR_W  = $clog2(MAX_BARS);
    localparam int unsigned AREA_W = HEIGHT_BITS + CNT_W;

    // fixed widths of the words on the ports
    localparam int unsigned IN_H_W     = 16;
    localparam int unsigned AREA_OUT_W = 26;
    localparam int unsigned POS_OUT_W  = 11;

    typedef struct packed {
        logic [PTR_W-1:0]       pos;
        logic [HEIGHT_BITS-1:0] height;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### rtl/core/histogram_largest_rectangle.sv
// Largest rectangle under a histogram, bars streamed in one word at a time.
// Input channel: i_in_valid / o_in_stall carry i_bar_height and i_last_bar.
//   A word is taken at a rising edge with i_in_valid high and o_in_stall low.
//   The word with i_last_bar set closes the histogram.
// Output channel: o_out_valid / i_out_stall carry one result word per
//   histogram: o_best_area, o_left_pos, o_right_pos (1-based, all zero when
//   no area above zero) and o_overflow (bars beyond MAX_BARS were dropped).
// Steps: a kept bar passes S_IDLE, S_CHECK and S_CMP, plus S_MUL and S_CMP
//   again for each stacked bar it pops. The closing bar also pops every entry
//   left on the stack, then S_DONE loads the result. Each pop reads the
//   entry below it from the stack RAM (none for the bottom entry), followed
//   by the height * width product and its compare with the best.
// Stall: the result sits in an output register; the next histogram's bars
//   are taken while it waits. A second result only waits for the first to
//   leave, holding o_in_stall high meanwhile.
// Reset (i_rst_n low, synchronous): counters, best area and flags clear; the
//   stack RAM is not cleared, only entries below the stack count are read.
// After each result the block clears itself for the next histogram.
`default_nettype none

module histogram_largest_rectangle (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [hlr_pkg::IN_H_W-1:0]     i_bar_height,
    input  wire logic                           i_last_bar,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [hlr_pkg::AREA_OUT_W-1:0]      o_best_area,
    output logic [hlr_pkg::POS_OUT_W-1:0]       o_left_pos,
    output logic [hlr_pkg::POS_OUT_W-1:0]       o_right_pos,
    output logic                                o_overflow
);

    import hlr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a bar
        S_CHECK,  // overflow test on the new bar
        S_CMP,    // score last pop, then pop / push / finish
        S_MUL,    // stack data back: width and area of the popped bar
        S_DONE    // load result word
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;     // stack depth
    logic [CNT_W-1:0]        r_bar;     // bars accepted this histogram
    logic [AREA_W-1:0]       r_best;
    logic [CNT_W-1:0]        r_left;
    logic [CNT_W-1:0]        r_right;
    logic                    r_ovf;
    logic                    r_flush;   // draining the stack after last bar
    logic                    r_ovalid;

    logic [HEIGHT_BITS-1:0]  r_h;
    logic                    r_last;
    t_entry                  r_top;     // register copy of the top of stack
    logic [AREA_W-1:0]       r_area;    // area of the bar just popped
    logic [CNT_W-1:0]        r_left_c;  // its left edge, 1-based

    logic                    want_pop;
    logic                    ram_we;
    logic                    ram_re;
    logic [PTR_W-1:0]        ram_raddr;
    t_entry                  push_entry;
    logic [ENTRY_W-1:0]      ram_rdata;
    t_entry                  below;
    logic [CNT_W-1:0]        n_width;

    assign want_pop   = (r_cnt != '0) && (r_flush || (r_top.height >= r_h));
    assign push_entry = '{pos: r_bar[PTR_W-1:0], height: r_h};
    assign ram_we     = (r_state == S_CMP) && !want_pop && !r_flush;
    assign ram_re     = (r_state == S_CMP) && want_pop && (r_cnt >= CNT_W'(2));
    assign ram_raddr  = PTR_W'(r_cnt - CNT_W'(2));
    assign below      = t_entry'(ram_rdata);

    // span of the popped bar: up to the entry below it, or the left edge
    always_comb begin
        if (r_cnt >= CNT_W'(2)) begin
            n_width = r_bar - CNT_W'(below.pos) - CNT_W'(1);
        end else begin
            n_width = r_bar;
        end
    end

    // writes go to the slot above the stack, reads to the entry just below
    // its top: the same entry is never read and written in one cycle
    hlr_stack_ram #(
        .DEPTH (MAX_BARS),
        .WIDTH (ENTRY_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[PTR_W-1:0]),
        .i_wdata (push_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_bar    <= '0;
            r_best   <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_ovf    <= 1'b0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // result load in S_DONE sets the flag itself
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_h     <= i_bar_height[HEIGHT_BITS-1:0];
                        r_last  <= i_last_bar;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_area <= '0;
                    if (r_bar >= CNT_W'(MAX_BARS)) begin
                        // bar dropped; a closing bar still drains the stack
                        r_ovf <= 1'b1;
                        if (r_last) begin
                            r_flush <= 1'b1;
                            r_state <= S_CMP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // strict compare: ties keep the earlier rectangle
                    if (r_area > r_best) begin
                        r_best  <= r_area;
                        r_left  <= r_left_c;
                        r_right <= r_bar;
                    end
                    if (want_pop) begin
                        r_state <= S_MUL;
                    end else if (!r_flush) begin
                        r_top <= push_entry;
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_bar <= r_bar + CNT_W'(1);
                        if (r_last) begin
                            r_flush <= 1'b1;
                            r_area  <= '0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_area   <= AREA_W'(r_top.height) * AREA_W'(n_width);
                    r_left_c <= r_bar - n_width + CNT_W'(1);
                    r_top    <= below;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    r_state  <= S_CMP;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        o_best_area <= AREA_OUT_W'(r_best);
                        o_left_pos  <= POS_OUT_W'(r_left);
                        o_right_pos <= POS_OUT_W'(r_right);
                        o_overflow  <= r_ovf;
                        r_ovalid    <= 1'b1;
                        r_cnt       <= '0;
                        r_bar       <= '0;
                        r_best      <= '0;
                        r_left      <= '0;
                        r_right     <= '0;
                        r_ovf       <= 1'b0;
                        r_flush     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    // stack never holds more entries than bars taken
    a_cnt_le_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_bar)
        else $error("stack depth above bar count");

    // no pop from an empty stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt != '0))
        else $error("pop with empty stack");

    // best area only grows within one histogram
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> (r_best >= $past(r_best)))
        else $error("best area shrank");

    // result load leaves the block cleared and idle
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_ovalid || !i_out_stall)) |=>
        ((r_cnt == '0) && (r_bar == '0) && (r_best == '0) && r_ovalid
         && (r_state == S_IDLE)))
        else $error("result load did not clear state");

    // drain ends with an empty stack
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cnt == '0))
        else $error("result with entries left on the stack");

endmodule

`default_nettype wire

### rtl/core/hlr_stack_ram.sv
`default_nettype none

module hlr_stack_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 26,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    import hlr_pkg::*;

    // quiet-cycle limit: ample room for a full-stack flush plus receiver stalls
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned DIR_ROWS    = 24;
    localparam int unsigned PHASE_WORDS = 180;

    // one result word as the block presents it
    typedef struct packed {
        logic [AREA_OUT_W-1:0] area;
        logic [POS_OUT_W-1:0]  left;
        logic [POS_OUT_W-1:0]  right;
        logic                  ovf;
    } t_span;

    // directed row: bar word, plus a hand-written result where one is obvious
    typedef struct packed {
        logic [IN_H_W-1:0] height;
        logic              last;
        logic              typed;
        t_span             want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // lone zero bar: no positive area, everything zero
        {16'd0,     1'b1, 1'b1, 26'd0,     11'd0, 11'd0, 1'b0},
        // lone tallest bar
        {16'hFFFF,  1'b1, 1'b1, 26'd65535, 11'd1, 11'd1, 1'b0},
        // lone unit bar
        {16'd1,     1'b1, 1'b1, 26'd1,     11'd1, 11'd1, 1'b0},
        // all-zero histogram
        {16'd0,     1'b0, 1'b0, 49'd0},
        {16'd0,     1'b0, 1'b0, 49'd0},
        {16'd0,     1'b1, 1'b1, 26'd0,     11'd0, 11'd0, 1'b0},
        // equal heights pop each other
        {16'd5,     1'b0, 1'b0, 49'd0},
        {16'd5,     1'b0, 1'b0, 49'd0},
        {16'd5,     1'b1, 1'b0, 49'd0},
        // textbook case, best is the 5,6 pair
        {16'd2,     1'b0, 1'b0, 49'd0},
        {16'd1,     1'b0, 1'b0, 49'd0},
        {16'd5,     1'b0, 1'b0, 49'd0},
        {16'd6,     1'b0, 1'b0, 49'd0},
        {16'd2,     1'b0, 1'b0, 49'd0},
        {16'd3,     1'b1, 1'b0, 49'd0},
        // tie between two areas: earliest wins
        {16'd3,     1'b0, 1'b0, 49'd0},
        {16'd0,     1'b0, 1'b0, 49'd0},
        {16'd3,     1'b1, 1'b0, 49'd0},
        // falling staircase, every bar pops
        {16'd4,     1'b0, 1'b0, 49'd0},
        {16'd3,     1'b0, 1'b0, 49'd0},
        {16'd2,     1'b0, 1'b0, 49'd0},
        {16'd1,     1'b1, 1'b0, 49'd0},
        // alternating bit patterns
        {16'hAAAA,  1'b0, 1'b0, 49'd0},
        {16'h5555,  1'b1, 1'b0, 49'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IN_H_W-1:0]     i_bar_height;
    logic                  i_last_bar;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [AREA_OUT_W-1:0] o_best_area;
    logic [POS_OUT_W-1:0]  o_left_pos;
    logic [POS_OUT_W-1:0]  o_right_pos;
    logic                  o_overflow;

    histogram_largest_rectangle uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bar_height (i_bar_height),
        .i_last_bar   (i_last_bar),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_best_area  (o_best_area),
        .o_left_pos   (o_left_pos),
        .o_right_pos  (o_right_pos),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: a private copy of the monotonic stack and the
    // running best rectangle of the histogram in progress.
    // ---------------------------------------------------------------------
    logic [PTR_W-1:0]       stk_pos    [MAX_BARS];
    logic [HEIGHT_BITS-1:0] stk_height [MAX_BARS];
    int unsigned            stk_depth  = 0;
    int unsigned            bars_seen  = 0;
    longint unsigned        best_area  = 0;
    longint unsigned        best_left  = 0;
    longint unsigned        best_right = 0;
    bit                     drop_seen  = 1'b0;

    t_span pending_spans [$];   // results still owed by the block
    int    mismatches    = 0;
    int    idle_pct      = 0;   // sender gap chance, per cent
    int    stall_pct     = 0;   // receiver stall chance, per cent
    int    quiet_cycles  = 0;

    // pop the top bar and score it against the bar index idx
    function automatic void pop_score(input int unsigned idx);
        longint unsigned width;
        longint unsigned area;
        stk_depth--;
        if (stk_depth == 0) begin
            width = idx;
        end else begin
            width = idx - stk_pos[stk_depth - 1] - 1;
        end
        area = longint'(stk_height[stk_depth]) * width;
        // strictly larger only, so ties keep the earliest rectangle
        if (area > best_area) begin
            best_area  = area;
            best_right = idx;
            best_left  = idx - width + 1;
        end
    endfunction

    // fold one accepted bar into the histogram; returns 1 with the span
    // when the bar closes the histogram
    function automatic bit fold_bar(input logic [IN_H_W-1:0] height,
                                    input logic last, output t_span span);
        logic [HEIGHT_BITS-1:0] h;
        int unsigned            idx;
        h    = height[HEIGHT_BITS-1:0];
        span = '0;
        if (bars_seen >= MAX_BARS) begin
            // histogram full: bar dropped, flag it
            drop_seen = 1'b1;
        end else begin
            idx = bars_seen;
            while (stk_depth > 0 && stk_height[stk_depth - 1] >= h) begin
                pop_score(idx);
            end
            if (stk_depth < MAX_BARS) begin
                stk_pos[stk_depth]    = idx[PTR_W-1:0];
                stk_height[stk_depth] = h;
                stk_depth++;
            end
            bars_seen++;
        end
        if (!last) begin
            return 1'b0;
        end
        // closing bar: flush what is left against the bar count
        while (stk_depth > 0) begin
            pop_score(bars_seen);
        end
        span.area  = best_area[AREA_OUT_W-1:0];
        span.left  = best_left[POS_OUT_W-1:0];
        span.right = best_right[POS_OUT_W-1:0];
        span.ovf   = drop_seen;
        bars_seen  = 0;
        best_area  = 0;
        best_left  = 0;
        best_right = 0;
        drop_seen  = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Sender: offers one bar word, holds it steady through stalls, and
    // records the expected result once the word is taken. A typed row
    // overrides the predicted result; the predictor still folds the bar.
    // ---------------------------------------------------------------------
    task automatic send_bar(input logic [IN_H_W-1:0] height, input logic last,
                            input logic typed, input t_span want);
        t_span span;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_bar_height <= height;
        i_last_bar   <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (fold_bar(height, last, span)) begin
            pending_spans.push_back(typed ? want : span);
        end
    endtask

    // hold the sender off until every owed result has come out
    task automatic drain;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_spans.size() != 0);
    endtask

    // one random histogram; height style varies to hit ties and extremes
    task automatic random_histogram(output int unsigned len);
        int unsigned            style;
        logic [IN_H_W-1:0]      h;
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                            : $urandom_range(1, 12);
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < len; i++) begin
            case (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : style)
                0: h = IN_H_W'($urandom_range(0, 65535));
                1: h = IN_H_W'($urandom_range(0, 7));          // dense ties
                2: h = IN_H_W'($urandom_range(65528, 65535));  // near the top
                default: h = IN_H_W'($urandom_range(0, 300));
            endcase
            send_bar(h, i == len - 1, 1'b0, '0);
        end
    endtask

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result checker: every word taken is matched against the oldest owed
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_spans.size() == 0) begin
                flag_mismatch("unexpected word, area", o_best_area, 0);
            end else begin
                want = pending_spans.pop_front();
                if (o_best_area !== want.area)
                    flag_mismatch("best_area", o_best_area, want.area);
                if (o_left_pos !== want.left)
                    flag_mismatch("left_pos", o_left_pos, want.left);
                if (o_right_pos !== want.right)
                    flag_mismatch("right_pos", o_right_pos, want.right);
                if (o_overflow !== want.ovf)
                    flag_mismatch("overflow", o_overflow, want.ovf);
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned len;
        int unsigned words;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_bar_height <= '0;
        i_last_bar   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_bar(DIRECTED[r].height, DIRECTED[r].last, DIRECTED[r].typed,
                     DIRECTED[r].want);
        end
        drain();

        // random histograms over four idling mixes; the sender drains
        // between mixes so the block starts each one empty
        for (int ph = 0; ph < 4; ph++) begin
            words = 0;
            while (words < PHASE_WORDS) begin
                case (ph)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 59; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 59; end
                    default: begin idle_pct = 26; stall_pct = 26; end
                endcase
                // now and then a burst with no idling at all
                if ($urandom_range(0, 5) == 0) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                random_histogram(len);
                words += len;
            end
            drain();
        end

        // full histogram: strictly rising bars fill the stack to MAX_BARS,
        // then two more are dropped, the closing one among them
        idle_pct  = 26;
        stall_pct = 26;
        for (int unsigned i = 0; i < MAX_BARS; i++) begin
            send_bar(IN_H_W'(65536 - MAX_BARS + i), 1'b0, 1'b0, '0);
        end
        send_bar(IN_H_W'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
        send_bar(IN_H_W'($urandom_range(0, 65535)), 1'b1, 1'b0, '0);

        // settle: everything owed, then a short tail for stray words
        drain();
        stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/hlr_pkg.sv
rtl/core/hlr_stack_ram.sv
rtl/core/histogram_largest_rectangle.sv
verif/tb.sv
